// ===== sv/imm_pkg.sv =====
`default_nettype none
package imm_pkg;

  localparam int CMD_W = 2;
  localparam int IDX_W = 3;
  localparam int VAL_W = 32;
  localparam int DIM_W = 4;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_idx_t;

  // tags that travel with one multiply-accumulate step
  typedef struct packed {
    logic             first;
    logic             fin;
    logic             last;
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
  } step_tag_t;

endpackage
`default_nettype wire

// ===== sv/integer_matrix_multiply.sv =====
// channel  | handshake            | payload
// ---------+----------------------+------------------------------------------
// command  | start, busy          | command, row, col, value
// config   | cfg_we               | cfg_addr, cfg_data
// result   | valid (one cycle)    | row_res, col_res, value_res, last, size_error
//
// a load is written to its store at the accepting edge
// a compute walks one multiply-accumulate step per cycle through the single
// read port of each store; results pass the read, product and output registers
// busy is high from the accept of a compute with matching sizes until the cycle the last result shows
// a size mismatch gives its error result in the cycle after the accept
// rst clears control registers and sets dimension registers to MAX_DIM; the stores are not cleared
`default_nettype none
module integer_matrix_multiply import imm_pkg::*; #(
  parameter int MAX_DIM    = 8,
  parameter int ELEM_WIDTH = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire  [CMD_W-1:0]      command,
  input  wire  [IDX_W-1:0]      row,
  input  wire  [IDX_W-1:0]      col,
  input  wire  signed [VAL_W-1:0] value,
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_addr,
  input  wire  [DIM_W-1:0]      cfg_data,
  output logic                  valid,
  output logic [IDX_W-1:0]      row_res,
  output logic [IDX_W-1:0]      col_res,
  output logic signed [VAL_W-1:0] value_res,
  output logic                  last,
  output logic                  size_error
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIM);

  logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
  logic [ELEM_WIDTH-1:0] b_mem [DEPTH];

  logic [DIM_W-1:0] a_rows, a_cols, b_rows, b_cols;
  logic [DIM_W-1:0] dim_clamped;

  logic             issuing;
  logic [IDX_W-1:0] r_cnt, c_cnt, k_cnt;
  logic             k_end, c_end, r_end;

  logic             accept, is_load, is_compute, load_ok;
  logic [AW-1:0]    ld_addr, a_raddr, b_raddr;

  logic [ELEM_WIDTH-1:0] a_q, b_q, prod, acc, acc_next;
  logic      v1, v2;
  step_tag_t tag0, tag1, tag2;

  assign accept     = start && !busy;
  assign is_load    = (command == CMD_LOAD_A) || (command == CMD_LOAD_B);
  assign is_compute = (command == CMD_COMPUTE);
  assign load_ok    = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
  assign ld_addr    = AW'(int'(row) * MAX_DIM + int'(col));

  assign dim_clamped = (cfg_data == '0) ? DIM_W'(1) :
                       (cfg_data > DIM_MAX) ? DIM_MAX : cfg_data;

  assign k_end = ({1'b0, k_cnt} + DIM_W'(1)) == b_rows;
  assign c_end = ({1'b0, c_cnt} + DIM_W'(1)) == b_cols;
  assign r_end = ({1'b0, r_cnt} + DIM_W'(1)) == a_rows;

  assign a_raddr = AW'(int'(r_cnt) * MAX_DIM + int'(k_cnt));
  assign b_raddr = AW'(int'(k_cnt) * MAX_DIM + int'(c_cnt));

  assign tag0.first = (k_cnt == '0);
  assign tag0.fin   = k_end;
  assign tag0.last  = k_end && c_end && r_end;
  assign tag0.r     = r_cnt;
  assign tag0.c     = c_cnt;

  assign acc_next = (tag2.first ? '0 : acc) + prod;

  // element stores: write on in-range load transfer, one registered read each
  always_ff @(posedge clk) begin
    if (accept && is_load && load_ok) begin
      if (command == CMD_LOAD_A) begin
        a_mem[ld_addr] <= value[ELEM_WIDTH-1:0];
      end else begin
        b_mem[ld_addr] <= value[ELEM_WIDTH-1:0];
      end
    end
    a_q <= a_mem[a_raddr];
    b_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_rows <= DIM_MAX;
      a_cols <= DIM_MAX;
      b_rows <= DIM_MAX;
      b_cols <= DIM_MAX;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_A_ROWS: a_rows <= dim_clamped;
        REG_A_COLS: a_cols <= dim_clamped;
        REG_B_ROWS: b_rows <= dim_clamped;
        REG_B_COLS: b_cols <= dim_clamped;
        default: ;
      endcase
    end
  end

  // walk sequencer: k innermost, then col, then row
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      busy    <= 1'b0;
      r_cnt   <= '0;
      c_cnt   <= '0;
      k_cnt   <= '0;
    end else begin
      if (accept && is_compute && (a_cols == b_rows)) begin
        issuing <= 1'b1;
        busy    <= 1'b1;
        r_cnt   <= '0;
        c_cnt   <= '0;
        k_cnt   <= '0;
      end else begin
        if (issuing) begin
          if (k_end) begin
            k_cnt <= '0;
            if (c_end) begin
              c_cnt <= '0;
              if (r_end) begin
                issuing <= 1'b0;
              end else begin
                r_cnt <= r_cnt + IDX_W'(1);
              end
            end else begin
              c_cnt <= c_cnt + IDX_W'(1);
            end
          end else begin
            k_cnt <= k_cnt + IDX_W'(1);
          end
        end
        if (v2 && tag2.fin && tag2.last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // read data, product, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issuing;
      v2 <= v1;
    end
    tag1 <= tag0;
    tag2 <= tag1;
    prod <= a_q * b_q;
    if (v2) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= (accept && is_compute && (a_cols != b_rows)) || (v2 && tag2.fin);
    end
    if (accept && is_compute && (a_cols != b_rows)) begin
      row_res    <= '0;
      col_res    <= '0;
      value_res  <= '0;
      last       <= 1'b0;
      size_error <= 1'b1;
    end else if (v2 && tag2.fin) begin
      row_res    <= tag2.r;
      col_res    <= tag2.c;
      value_res  <= VAL_W'($signed(acc_next));
      last       <= tag2.last;
      size_error <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/imm_checker.sv =====
`default_nettype none
module imm_checker import imm_pkg::*; (
  input wire                   clk,
  input wire                   rst,
  input wire                   start,
  input wire                   busy,
  input wire [CMD_W-1:0]       command,
  input wire                   valid,
  input wire [IDX_W-1:0]       row_res,
  input wire [IDX_W-1:0]       col_res,
  input wire [VAL_W-1:0]       value_res,
  input wire                   last,
  input wire                   size_error
);

  // an error result carries nothing else
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    valid && size_error |-> !last && row_res == '0 && col_res == '0 && value_res == '0)
    else $error("size error result with nonzero fields");

  // an error result follows a compute transfer directly
  a_err_after_cmd: assert property (@(posedge clk) disable iff (rst)
    valid && size_error |-> $past(start && !busy && command == CMD_COMPUTE))
    else $error("size error result without compute transfer");

  // product results other than the final one appear only while busy
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !size_error && !last |-> busy)
    else $error("product result while idle");

  // busy drops exactly with the final product result
  a_busy_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> valid && last && !size_error)
    else $error("busy fell without final result");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .command    (command),
  .valid      (valid),
  .row_res    (row_res),
  .col_res    (col_res),
  .value_res  (value_res),
  .last       (last),
  .size_error (size_error)
);
`default_nettype wire
